// ===== hdl/phad_pkg.sv =====
`timescale 1ns / 1ps
// Package for the prefixed hex address decoder.
// Holds the status and kind codes, prefix characters, sizes and the digit decode.
// No dependencies.

package phad_pkg;

	// Identifier size and text layout
	localparam int ID_BYTES = 32;
	localparam int ID_BITS  = 8 * ID_BYTES;
	localparam int COUNT_W  = 7;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;
	localparam logic [COUNT_W-1:0] DIGITS    = 7'(2 * ID_BYTES);
	// digits start after "stn0_" or after "stnc0_" / "stnw0_"
	localparam logic [COUNT_W-1:0] OFF_SHORT = 7'd5;
	localparam logic [COUNT_W-1:0] OFF_LONG  = 7'd6;

	// Result status
	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_LENGTH = 2'd1,
		STATUS_PREFIX = 2'd2,
		STATUS_DIGIT  = 2'd3
	} status_t;

	// Address kind, picked by the fourth character
	typedef enum logic [1:0] {
		KIND_IDENTITY = 2'd0,
		KIND_CONTRACT = 2'd1,
		KIND_WALLET   = 2'd2
	} kind_t;

	// Prefix characters
	localparam logic [7:0] CH_S     = "s";
	localparam logic [7:0] CH_T     = "t";
	localparam logic [7:0] CH_N     = "n";
	localparam logic [7:0] CH_ZERO  = "0";
	localparam logic [7:0] CH_NINE  = "9";
	localparam logic [7:0] CH_C     = "c";
	localparam logic [7:0] CH_W     = "w";
	localparam logic [7:0] CH_A     = "a";
	localparam logic [7:0] CH_F     = "f";
	localparam logic [7:0] CH_UNDER = "_";

	// Expected character at one of the three leading positions
	function automatic logic [7:0] lead_char(input logic [1:0] pos);
		logic [7:0] ch;
		case (pos)
			2'd0:    ch = CH_S;
			2'd1:    ch = CH_T;
			default: ch = CH_N;
		endcase
		return ch;
	endfunction

	// Lower-case hex digit decode: {valid, nibble}
	function automatic logic [4:0] hex_decode(input logic [7:0] ch);
		logic [7:0] diff;
		logic [4:0] res;
		res = 5'd0;
		if (ch >= CH_ZERO && ch <= CH_NINE) begin
			diff = ch - CH_ZERO;
			res  = {1'b1, diff[3:0]};
		end else if (ch >= CH_A && ch <= CH_F) begin
			diff = ch - CH_A + 8'd10;
			res  = {1'b1, diff[3:0]};
		end
		return res;
	endfunction

endpackage

// ===== hdl/prefixed_hex_address_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the prefixed hex address decoder.
// Depends on phad_pkg for codes, constants and the hex digit decode.

// Prefixed hex address decoder
//
// Input channel: one text character per word (char_code, is_final), taken at
// a rising edge with char_valid high and char_stall low. is_final marks the
// last character of an address text.
// Output channel: one result word per text (status, addr_kind, id_word0..3),
// taken at a rising edge with result_valid high and result_stall low.
// Identifier words and kind are zero unless status is ok.
//
// Throughput: one character per cycle, sustained, as long as the receiver
// keeps up. A final character passes through the input register, then the
// result register, before its result is valid.
// The character path is a single short stage: prefix compare, nibble
// decode and a byte shift into the 256-bit identifier register.
//
// Reset (arst_n low) clears the character count, prefix and error flags
// and both valid registers; the identifier register is not cleared.
// When the receiver stalls a held result, non-final characters keep
// flowing; a second final character waits in the input register and
// char_stall rises until the result slot frees up.

module prefixed_hex_address_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  char_code,
	input  logic        is_final,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  status,
	output logic [1:0]  addr_kind,
	output logic [63:0] id_word0,
	output logic [63:0] id_word1,
	output logic [63:0] id_word2,
	output logic [63:0] id_word3
);

	localparam int CW = phad_pkg::COUNT_W;
	localparam int IB = phad_pkg::ID_BITS;

	// Input register
	logic         valid_s1;
	logic [7:0]   char_s1;
	logic         final_s1;

	// Per-text state
	logic [CW-1:0]   count_q;
	phad_pkg::kind_t kind_q;
	logic            pbad_q;
	logic            dbad_q;
	logic [3:0]      pend_q;
	logic [IB-1:0]   store_q;

	// Result register
	logic              res_valid_q;
	phad_pkg::status_t status_q;
	logic [1:0]        kind_out_q;
	logic [63:0]       word0_q, word1_q, word2_q, word3_q;

	// Next-state values
	phad_pkg::kind_t   kind_n;
	logic              pbad_n, dbad_n;
	logic [3:0]        pend_n;
	logic [3:0]        nib;
	logic [4:0]        hex;
	logic              byte_we;
	logic [7:0]        byte_val;
	logic [CW-1:0]     off, off_n, dpos;
	logic [IB-1:0]     store_n;
	phad_pkg::status_t status_n;
	logic              advance;
	logic              accept;

	// Handshake: a final word moves on only when the result slot is free
	assign advance    = valid_s1 && (!final_s1 || !res_valid_q || !result_stall);
	assign char_stall = valid_s1 && !advance;
	assign accept     = char_valid && !char_stall;

	// Character step
	always_comb begin
		kind_n   = kind_q;
		pbad_n   = pbad_q;
		dbad_n   = dbad_q;
		pend_n   = pend_q;
		byte_we  = 1'b0;
		hex      = phad_pkg::hex_decode(char_s1);
		nib      = hex[4] ? hex[3:0] : 4'd0;
		byte_val = {pend_q, nib};
		off      = (kind_q == phad_pkg::KIND_IDENTITY) ? phad_pkg::OFF_SHORT
		                                               : phad_pkg::OFF_LONG;
		dpos     = count_q - off;
		if (count_q != phad_pkg::COUNT_MAX) begin
			if (count_q <= 7'd2) begin
				if (char_s1 != phad_pkg::lead_char(count_q[1:0])) pbad_n = 1'b1;
			end else if (count_q == 7'd3) begin
				case (char_s1)
					phad_pkg::CH_ZERO: kind_n = phad_pkg::KIND_IDENTITY;
					phad_pkg::CH_C:    kind_n = phad_pkg::KIND_CONTRACT;
					phad_pkg::CH_W:    kind_n = phad_pkg::KIND_WALLET;
					default:           pbad_n = 1'b1;
				endcase
			end else if (!pbad_q) begin
				if (count_q == 7'd4) begin
					if (char_s1 != ((kind_q == phad_pkg::KIND_IDENTITY) ?
					                phad_pkg::CH_UNDER : phad_pkg::CH_ZERO))
						pbad_n = 1'b1;
				end else if (count_q == 7'd5 && kind_q != phad_pkg::KIND_IDENTITY) begin
					if (char_s1 != phad_pkg::CH_UNDER) pbad_n = 1'b1;
				end else if (count_q >= off && count_q < off + phad_pkg::DIGITS) begin
					if (!hex[4]) dbad_n = 1'b1;
					if (!dpos[0]) begin
						pend_n = nib;
					end else begin
						byte_we = 1'b1;
					end
				end
			end
		end
		// bytes arrive in order, so on success the last 32 shifted in are the identifier
		store_n = byte_we ? {store_q[IB-9:0], byte_val} : store_q;
	end

	// Status on the final character, from the updated flags
	always_comb begin
		off_n = (kind_n == phad_pkg::KIND_IDENTITY) ? phad_pkg::OFF_SHORT
		                                            : phad_pkg::OFF_LONG;
		if (count_q != phad_pkg::OFF_SHORT + phad_pkg::DIGITS - 7'd1 &&
		    count_q != phad_pkg::OFF_LONG + phad_pkg::DIGITS - 7'd1) begin
			status_n = phad_pkg::STATUS_LENGTH;
		end else if (pbad_n) begin
			status_n = phad_pkg::STATUS_PREFIX;
		end else if (count_q != off_n + phad_pkg::DIGITS - 7'd1) begin
			status_n = phad_pkg::STATUS_LENGTH;
		end else if (dbad_n) begin
			status_n = phad_pkg::STATUS_DIGIT;
		end else begin
			status_n = phad_pkg::STATUS_OK;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1  <= char_code;
			final_s1 <= is_final;
		end
	end

	// Per-text state; cleared after each final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			kind_q  <= phad_pkg::KIND_IDENTITY;
			pbad_q  <= 1'b0;
			dbad_q  <= 1'b0;
			pend_q  <= 4'd0;
		end else if (advance) begin
			if (final_s1) begin
				count_q <= '0;
				kind_q  <= phad_pkg::KIND_IDENTITY;
				pbad_q  <= 1'b0;
				dbad_q  <= 1'b0;
				pend_q  <= 4'd0;
			end else begin
				count_q <= count_q + CW'(count_q != phad_pkg::COUNT_MAX);
				kind_q  <= kind_n;
				pbad_q  <= pbad_n;
				dbad_q  <= dbad_n;
				pend_q  <= pend_n;
			end
		end
	end

	// Identifier shift register
	always_ff @(posedge clk) begin
		if (advance) store_q <= store_n;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && final_s1) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && final_s1) begin
			status_q <= status_n;
			if (status_n == phad_pkg::STATUS_OK) begin
				kind_out_q <= kind_n;
				word0_q    <= store_n[IB-1     -: 64];
				word1_q    <= store_n[IB-1-64  -: 64];
				word2_q    <= store_n[IB-1-128 -: 64];
				word3_q    <= store_n[IB-1-192 -: 64];
			end else begin
				kind_out_q <= phad_pkg::KIND_IDENTITY;
				word0_q    <= 64'd0;
				word1_q    <= 64'd0;
				word2_q    <= 64'd0;
				word3_q    <= 64'd0;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign status       = status_q;
	assign addr_kind    = kind_out_q;
	assign id_word0     = word0_q;
	assign id_word1     = word1_q;
	assign id_word2     = word2_q;
	assign id_word3     = word3_q;

endmodule
